// ===== src/hpm_pkg.sv =====
// Shared types, constants and helpers for the hazard persistence monitor.
package hpm_pkg;

  localparam int TIMER_WIDTH = 26;
  localparam int HOLD_W      = 26;
  localparam int SPEED_W     = 15;
  localparam int VS_W        = 16;
  localparam int DT_W        = 16;
  localparam int NUM_CH      = 5;
  localparam int CFG_IDX_W   = 3;
  localparam int CMP_W       = (TIMER_WIDTH > HOLD_W) ? TIMER_WIDTH : HOLD_W;

  // input and output beat widths
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 8;

  typedef logic [TIMER_WIDTH-1:0] timer_t;
  typedef logic [HOLD_W-1:0]      hold_t;
  typedef logic [SPEED_W-1:0]     speed_t;
  typedef logic [DT_W-1:0]        dt_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_CRIT = 2'd1,
    ST_DEAD = 2'd2
  } st_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_PRESS  = 3'd0,
    REG_HIGH_PRESS = 3'd1,
    REG_TEMP       = 3'd2,
    REG_CO2        = 3'd3,
    REG_ACCEL      = 3'd4,
    REG_SPEED_LIM  = 3'd5
  } reg_idx_e;

  // channel order matches the hold registers
  localparam int CH_LOW_PRESS  = 0;
  localparam int CH_HIGH_PRESS = 1;
  localparam int CH_TEMP       = 2;
  localparam int CH_CO2        = 3;
  localparam int CH_ACCEL      = 4;

  localparam hold_t  HOLD_RESET [NUM_CH] = '{
    HOLD_W'(600000), HOLD_W'(3600000), HOLD_W'(43200000),
    HOLD_W'(1800000), HOLD_W'(10000)
  };
  localparam speed_t SPEED_LIM_RESET = SPEED_W'(1500);

  // sensor thresholds
  localparam logic [15:0] PRESS_LOW_LIM  = 16'd280;
  localparam logic [15:0] PRESS_HIGH_LIM = 16'd2200;
  localparam logic [12:0] TEMP_HIGH_LIM  = 13'd3200;
  localparam logic [12:0] TEMP_LOW_LIM   = 13'd2700;
  localparam logic [11:0] CO2_LIM        = 12'd100;
  localparam logic [15:0] ACCEL_LIM      = 16'd12000;

  localparam timer_t TIMER_MAX = {TIMER_WIDTH{1'b1}};

  typedef struct packed {
    logic [NUM_CH-1:0][HOLD_W-1:0] hold;
    speed_t                        speed_lim;
  } cfg_t;

  typedef struct packed {
    logic crit;
    logic dead;
  } ch_sum_t;

  // hold value clipped to what the timer can hold
  function automatic timer_t load_value(hold_t h);
    logic [CMP_W-1:0] h_ext;
    logic [CMP_W-1:0] max_ext;
    h_ext   = CMP_W'(h);
    max_ext = CMP_W'(TIMER_MAX);
    return (h_ext > max_ext) ? TIMER_MAX : TIMER_WIDTH'(h_ext);
  endfunction

endpackage

// ===== src/hazard_persistence_monitor_core.sv =====
// Crew hazard monitor: one status beat out for every sensor tick in.
//
// Channels: s_axis carries one tick per beat (elapsed time and suit and
// vehicle readings); m_axis returns crew_state and became_dead for each
// tick, in order. cfg_we_i/cfg_idx_i/cfg_wdata_i write the five hold times
// and the touchdown speed limit; write them only while no tick is in flight.
// A tick is held in the input register, then in the result register, and
// is then shown on m_axis. Throughput: one tick per cycle while m_axis is not
// stalled, set by the single compare/subtract stage that updates the hold timers
// and the health state between the two registers.
// Reset: health is ok, every timer is loaded with its reset hold time, the
// stored airborne speed is zero and both stages are empty.
// Stall: when m_axis_tready is low the result stays put, the input stage
// fills and s_axis_tready then drops; nothing is lost or repeated.
module hazard_persistence_monitor_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // tdata: elapsed_ms[15:0], crew_present[16], suit_pressure[32:17],
  // suit_temperature[45:33], suit_co2[57:46], accel_magnitude[73:58],
  // ground_contact[74], vertical_speed[90:75], zero[95:91]
  input  logic [hpm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: crew_state[1:0], became_dead[2], zero[7:3]
  output logic [hpm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic                           cfg_we_i,
  input  logic [hpm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [hpm_pkg::HOLD_W-1:0]     cfg_wdata_i
);
  import hpm_pkg::*;

  cfg_t    cfg;
  ch_sum_t ch_sum;

  logic                 in_vld_q, in_vld_d;
  logic [IN_DATA_W-1:0] in_data_q;
  logic                 out_vld_q, out_vld_d;
  st_e                  out_st_q, out_st_d;
  logic                 out_bd_q, out_bd_d;
  st_e                  health_q, health_d;
  logic [VS_W-1:0]      speed_q, speed_d;

  logic                 adv;
  logic                 upd;

  dt_t                  dt;
  logic                 crew;
  logic [15:0]          press;
  logic [12:0]          temp;
  logic [11:0]          co2;
  logic [15:0]          accel;
  logic                 ground;
  logic [VS_W-1:0]      vs;
  logic [NUM_CH-1:0]    bad;
  logic [VS_W:0]        mag;
  logic                 crash;
  st_e                  st_new;

  hpm_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .cfg_o (cfg)
  );

  assign dt     = in_data_q[15:0];
  assign crew   = in_data_q[16];
  assign press  = in_data_q[32:17];
  assign temp   = in_data_q[45:33];
  assign co2    = in_data_q[57:46];
  assign accel  = in_data_q[73:58];
  assign ground = in_data_q[74];
  assign vs     = in_data_q[90:75];

  assign adv = !out_vld_q || m_axis_tready;
  assign upd = adv && in_vld_q && crew && (health_q != ST_DEAD);

  always_comb begin
    bad                = '0;
    bad[CH_LOW_PRESS]  = press < PRESS_LOW_LIM;
    bad[CH_HIGH_PRESS] = press > PRESS_HIGH_LIM;
    bad[CH_TEMP]       = (temp > TEMP_HIGH_LIM) || (temp < TEMP_LOW_LIM);
    bad[CH_CO2]        = co2 > CO2_LIM;
    bad[CH_ACCEL]      = accel > ACCEL_LIM;
  end

  hpm_timer_bank u_timers (
    .clk_i,
    .rst_ni,
    .upd_i (upd),
    .bad_i (bad),
    .cfg_i (cfg),
    .dt_i  (dt),
    .sum_o (ch_sum)
  );

  // magnitude of the stored speed; most negative value needs the extra bit
  assign mag   = speed_q[VS_W-1] ? ((VS_W+1)'(0) - {speed_q[VS_W-1], speed_q})
                                 : {1'b0, speed_q};
  assign crash = ground && (mag > (VS_W+1)'(cfg.speed_lim));

  always_comb begin
    priority if (ch_sum.dead || crash) begin
      st_new = ST_DEAD;
    end else if (ch_sum.crit) begin
      st_new = ST_CRIT;
    end else begin
      st_new = ST_OK;
    end
  end

  always_comb begin
    health_d  = health_q;
    speed_d   = speed_q;
    in_vld_d  = in_vld_q;
    out_vld_d = out_vld_q;
    out_st_d  = out_st_q;
    out_bd_d  = out_bd_q;
    if (adv) begin
      out_vld_d = in_vld_q;
      in_vld_d  = s_axis_tvalid;
      if (in_vld_q) begin
        out_st_d = health_q;
        out_bd_d = 1'b0;
        if (upd) begin
          health_d = st_new;
          out_st_d = st_new;
          out_bd_d = (st_new == ST_DEAD);
          if (!ground) speed_d = vs;
        end
      end
    end else if (!in_vld_q) begin
      in_vld_d = s_axis_tvalid;
    end
  end

  assign s_axis_tready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      health_q  <= ST_OK;
      speed_q   <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      health_q  <= health_d;
      speed_q   <= speed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) in_data_q <= s_axis_tdata;
    out_st_q <= out_st_d;
    out_bd_q <= out_bd_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'b0, out_bd_q, out_st_q};

endmodule

// ===== src/hpm_cfg_regs.sv =====
// Configuration register file: hold times and touchdown speed limit.
module hpm_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hpm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [hpm_pkg::HOLD_W-1:0]    cfg_wdata_i,
  output hpm_pkg::cfg_t                 cfg_o
);
  import hpm_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_LOW_PRESS:  cfg_d.hold[CH_LOW_PRESS]  = cfg_wdata_i;
        REG_HIGH_PRESS: cfg_d.hold[CH_HIGH_PRESS] = cfg_wdata_i;
        REG_TEMP:       cfg_d.hold[CH_TEMP]       = cfg_wdata_i;
        REG_CO2:        cfg_d.hold[CH_CO2]        = cfg_wdata_i;
        REG_ACCEL:      cfg_d.hold[CH_ACCEL]      = cfg_wdata_i;
        REG_SPEED_LIM:  cfg_d.speed_lim           = cfg_wdata_i[SPEED_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CH; i++) cfg_q.hold[i] <= HOLD_RESET[i];
      cfg_q.speed_lim <= SPEED_LIM_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/hpm_timer_bank.sv =====
// Hold timers of the five hazard channels and their combined status.
module hpm_timer_bank (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       upd_i,
  input  logic [hpm_pkg::NUM_CH-1:0] bad_i,
  input  hpm_pkg::cfg_t              cfg_i,
  input  hpm_pkg::dt_t               dt_i,
  output hpm_pkg::ch_sum_t           sum_o
);
  import hpm_pkg::*;

  timer_t              timer_q [NUM_CH];
  timer_t              timer_d [NUM_CH];
  logic   [NUM_CH-1:0] crit;
  logic   [NUM_CH-1:0] dead;
  timer_t              dt_ext;

  assign dt_ext = TIMER_WIDTH'(dt_i);

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      dead[i]    = bad_i[i] && (timer_q[i] == '0);
      crit[i]    = bad_i[i] && (timer_q[i] != '0);
      timer_d[i] = timer_q[i];
      if (!bad_i[i]) begin
        timer_d[i] = load_value(cfg_i.hold[i]);
      end else if (timer_q[i] > dt_ext) begin
        timer_d[i] = timer_q[i] - dt_ext;
      end else begin
        timer_d[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CH; i++) timer_q[i] <= load_value(HOLD_RESET[i]);
    end else if (upd_i) begin
      for (int i = 0; i < NUM_CH; i++) timer_q[i] <= timer_d[i];
    end
  end

  assign sum_o.crit = |crit;
  assign sum_o.dead = |dead;

endmodule

// ===== src/hpm_checker.sv =====
// Port-level checks for the hazard monitor, bound to the top level.
module hpm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic [hpm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready
);
  import hpm_pkg::*;

  logic beat;
  logic is_dead;
  logic bd;

  assign beat    = m_axis_tvalid && m_axis_tready;
  assign is_dead = (m_axis_tdata[1:0] == ST_DEAD);
  assign bd      = m_axis_tdata[2];

  a_bd_means_dead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && bd) |-> is_dead)
    else $error("became_dead without dead state");

  a_state_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3))
    else $error("illegal crew_state");

  a_dead_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat && is_dead) |=> (!beat || (is_dead && !bd)))
    else $error("dead state not sticky or became_dead repeated");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind hazard_persistence_monitor_core hpm_checker u_hpm_checker (
  .clk_i,
  .rst_ni,
  .m_axis_tdata,
  .m_axis_tvalid,
  .m_axis_tready
);

// ===== tb/tb_hazard_persistence_monitor_core.sv =====
`timescale 1ns / 1ps
// Self-checking stream testbench for the crew hazard persistence monitor core.
module tb_hazard_persistence_monitor_core;
  import hpm_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  localparam int LOW_PRESS_FLOOR = 280;
  localparam int HIGH_PRESS_CEIL = 2200;
  localparam int TEMP_FLOOR      = 2700;
  localparam int TEMP_CEIL       = 3200;
  localparam int CO2_CEIL        = 100;
  localparam int ACCEL_CEIL      = 12000;

  localparam int unsigned RESET_HOLD [NUM_CH] = '{600000, 3600000, 43200000, 1800000, 10000};
  localparam int unsigned RESET_SPEED_LIM = 1500;
  localparam timer_t TIMER_TOP = '1;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef enum int {DEATH_BY_EXPIRY, DEATH_BY_LANDING, DEATH_BY_ZERO_HOLD} death_cause_e;

  typedef struct packed {
    logic [15:0]        elapsed;
    logic               crew;
    logic [15:0]        press;
    logic [12:0]        temp;
    logic [11:0]        co2;
    logic [15:0]        accel;
    logic               gnd;
    logic signed [15:0] vs;
  } tick_t;

  typedef struct packed {
    st_e  crew_state;
    logic became_dead;
  } status_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [HOLD_W-1:0]     cfg_wdata = '0;

  // monitor model state
  st_e                    health_q;
  timer_t                 timer_q [NUM_CH];
  hold_t                  hold_q [NUM_CH];
  speed_t                 speed_lim_q;
  logic signed [VS_W-1:0] air_speed_q;
  logic [NUM_CH-1:0]      episode_q;
  status_t                pending_status_q [$];

  int mismatches = 0;
  int cycle_count = 0;
  int rx_hold = 0;
  bit tx_idle_en = 1'b1;
  bit rx_stall_en = 1'b1;

  always #10 clk = ~clk;

  hazard_persistence_monitor_core DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata)
  );

  function automatic int idle_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic timer_t clip_hold(hold_t h);
    return (64'(h) > 64'(TIMER_TOP)) ? TIMER_TOP : timer_t'(h);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  task automatic predict_crew_status(input tick_t t);
    logic [NUM_CH-1:0] bad;
    st_e st;
    int mag;
    status_t res;
    res.became_dead = 1'b0;
    if (health_q != ST_DEAD && t.crew) begin
      bad[CH_LOW_PRESS]  = t.press < LOW_PRESS_FLOOR;
      bad[CH_HIGH_PRESS] = t.press > HIGH_PRESS_CEIL;
      bad[CH_TEMP]       = t.temp > TEMP_CEIL || t.temp < TEMP_FLOOR;
      bad[CH_CO2]        = t.co2 > CO2_CEIL;
      bad[CH_ACCEL]      = t.accel > ACCEL_CEIL;
      st = ST_OK;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        if (!bad[ch]) begin
          timer_q[ch] = clip_hold(hold_q[ch]);
        end else if (timer_q[ch] == '0) begin
          st = ST_DEAD;
        end else begin
          timer_q[ch] = (timer_q[ch] > t.elapsed) ? timer_q[ch] - t.elapsed : '0;
          if (st != ST_DEAD) st = ST_CRIT;
        end
      end
      if (t.gnd) begin
        mag = int'(air_speed_q);
        if (mag < 0) mag = -mag;
        if (mag > int'(speed_lim_q)) st = ST_DEAD;
      end else begin
        air_speed_q = t.vs;
      end
      res.became_dead = (st == ST_DEAD);
      health_q = st;
    end
    res.crew_state = health_q;
    pending_status_q.push_back(res);
  endtask

  function automatic tick_t mk_tick(int dt, int crew, int press, int temp, int co2,
                                    int accel, int gnd, int vs);
    tick_t t;
    t.elapsed = 16'(dt);
    t.crew    = 1'(crew);
    t.press   = 16'(press);
    t.temp    = 13'(temp);
    t.co2     = 12'(co2);
    t.accel   = 16'(accel);
    t.gnd     = 1'(gnd);
    t.vs      = 16'(vs);
    return t;
  endfunction

  // guarded ticks keep the crew alive: a channel whose timer ran out must recover,
  // and touchdown only happens at a survivable stored speed
  function automatic tick_t gen_tick(bit guarded);
    tick_t t;
    logic [NUM_CH-1:0] bad;
    int lim, mag, r;
    r = $urandom_range(0, 9);
    t.elapsed = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF :
                (r < 6) ? 16'($urandom_range(1, 1000)) : 16'($urandom);
    t.crew = $urandom_range(0, 9) != 0;
    if (!guarded || !t.crew) begin
      t.press = 16'($urandom);
      t.temp  = 13'($urandom);
      t.co2   = 12'($urandom);
      t.accel = 16'($urandom);
      t.gnd   = 1'($urandom);
      t.vs    = 16'($urandom);
      return t;
    end
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if ($urandom_range(0, 4) == 0) episode_q[ch] = !episode_q[ch];
      if (timer_q[ch] == '0) episode_q[ch] = 1'b0;
    end
    bad = episode_q;
    if (bad[CH_LOW_PRESS]) bad[CH_HIGH_PRESS] = 1'b0;
    t.press = bad[CH_LOW_PRESS]  ? 16'($urandom_range(0, LOW_PRESS_FLOOR - 1)) :
              bad[CH_HIGH_PRESS] ? 16'($urandom_range(HIGH_PRESS_CEIL + 1, 65535)) :
                                   16'($urandom_range(LOW_PRESS_FLOOR, HIGH_PRESS_CEIL));
    if (!bad[CH_TEMP]) t.temp = 13'($urandom_range(TEMP_FLOOR, TEMP_CEIL));
    else if ($urandom_range(0, 1) == 0) t.temp = 13'($urandom_range(0, TEMP_FLOOR - 1));
    else t.temp = 13'($urandom_range(TEMP_CEIL + 1, 8191));
    t.co2 = bad[CH_CO2] ? 12'($urandom_range(CO2_CEIL + 1, 4095)) :
                          12'($urandom_range(0, CO2_CEIL));
    t.accel = bad[CH_ACCEL] ? 16'($urandom_range(ACCEL_CEIL + 1, 65535)) :
                              16'($urandom_range(0, ACCEL_CEIL));
    lim = int'(speed_lim_q);
    case ($urandom_range(0, 9))
      0: t.vs = 16'sh0000;
      1: t.vs = 16'sh8000;
      2: t.vs = 16'sh7FFF;
      3, 4: t.vs = 16'($urandom);
      5: t.vs = 16'(lim);
      6: t.vs = 16'(-lim);
      default: t.vs = 16'(int'($urandom_range(0, 2 * lim)) - lim);
    endcase
    mag = int'(air_speed_q);
    if (mag < 0) mag = -mag;
    t.gnd = (mag <= lim) && ($urandom_range(0, 3) == 0);
    return t;
  endfunction

  task automatic send_tick(input tick_t t);
    int gap;
    gap = (tx_idle_en && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'({t.vs, t.gnd, t.accel, t.co2, t.temp, t.press, t.crew,
                                 t.elapsed});
    do @(posedge clk); while (!s_axis_tready);
    predict_crew_status(t);
  endtask

  task automatic drain_ticks();
    s_axis_tvalid <= 1'b0;
    while (pending_status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HOLD_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      REG_LOW_PRESS:  hold_q[CH_LOW_PRESS]  = value;
      REG_HIGH_PRESS: hold_q[CH_HIGH_PRESS] = value;
      REG_TEMP:       hold_q[CH_TEMP]       = value;
      REG_CO2:        hold_q[CH_CO2]        = value;
      REG_ACCEL:      hold_q[CH_ACCEL]      = value;
      REG_SPEED_LIM:  speed_lim_q           = value[SPEED_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_config(input hold_t lp, input hold_t hp, input hold_t tp,
                              input hold_t co, input hold_t ac, input speed_t lim);
    write_reg(REG_LOW_PRESS, lp);
    write_reg(REG_HIGH_PRESS, hp);
    write_reg(REG_TEMP, tp);
    write_reg(REG_CO2, co);
    write_reg(REG_ACCEL, ac);
    write_reg(REG_SPEED_LIM, HOLD_W'(lim));
  endtask

  task automatic test_boundaries();
    send_tick(mk_tick(100, 1, 1470, 2950, 50, 1000, 0, 0));
    send_tick(mk_tick(65535, 0, 0, 8191, 4095, 65535, 1, -32768));
    send_tick(mk_tick(65535, 1, 279, 2950, 50, 1000, 0, 0));
    send_tick(mk_tick(10, 1, 280, 2700, 100, 12000, 0, 0));
    send_tick(mk_tick(10, 1, 2200, 3200, 100, 12000, 0, 0));
    send_tick(mk_tick(10, 1, 2201, 2950, 50, 1000, 0, 0));
    send_tick(mk_tick(65535, 1, 65535, 2950, 50, 1000, 0, 0));
    send_tick(mk_tick(1, 1, 1470, 2699, 50, 1000, 0, 0));
    send_tick(mk_tick(1, 1, 1470, 3201, 50, 1000, 0, 0));
    send_tick(mk_tick(1, 1, 1470, 0, 50, 1000, 0, 0));
    send_tick(mk_tick(1, 1, 1470, 8191, 50, 1000, 0, 0));
    send_tick(mk_tick(1, 1, 1470, 2950, 101, 1000, 0, 0));
    send_tick(mk_tick(1, 1, 1470, 2950, 4095, 1000, 0, 0));
    send_tick(mk_tick(0, 1, 1470, 2950, 50, 12001, 0, 0));
    send_tick(mk_tick(0, 1, 1470, 2950, 50, 65535, 0, 32767));
    send_tick(mk_tick(100, 1, 1470, 2950, 50, 1000, 0, -32768));
    send_tick(mk_tick(100, 1, 1470, 2950, 50, 1000, 0, -1500));
    // landing right at the limit survives, stored speed is kept on the ground
    send_tick(mk_tick(100, 1, 1470, 2950, 50, 1000, 1, 12345));
    send_tick(mk_tick(100, 1, 1470, 2950, 50, 1000, 1, -32768));
    // every channel but high pressure out at once; accel timer runs down to zero
    send_tick(mk_tick(65535, 1, 0, 8191, 4095, 65535, 0, 1500));
    send_tick(mk_tick(65535, 0, 0, 8191, 4095, 65535, 0, 0));
    send_tick(mk_tick(100, 1, 1470, 2950, 50, 1000, 0, 0));
    send_tick(mk_tick(100, 1, 1470, 2950, 50, 1000, 1, 0));
    send_tick(mk_tick(0, 1, 0, 2950, 50, 1000, 0, 0));
    drain_ticks();
  endtask

  task automatic test_short_holds();
    write_config(hold_t'($urandom_range(1, 150000)), hold_t'($urandom_range(1, 150000)),
                 hold_t'($urandom_range(1, 150000)), hold_t'($urandom_range(1, 150000)),
                 hold_t'($urandom_range(1, 150000)), speed_t'($urandom_range(0, 32767)));
    repeat (200) send_tick(gen_tick(1'b1));
    drain_ticks();
  endtask

  task automatic test_extreme_holds();
    write_config(hold_t'(1), '1, hold_t'($urandom_range(1, 5000)), '0, hold_t'(65535), '0);
    repeat (200) send_tick(gen_tick(1'b1));
    drain_ticks();
  endtask

  task automatic test_wide_holds();
    write_config(hold_t'($urandom), hold_t'($urandom), hold_t'($urandom), hold_t'($urandom),
                 hold_t'($urandom), '1);
    write_reg(REG_SPARE_LO, HOLD_W'($urandom));
    write_reg(REG_SPARE_HI, '0);
    tx_idle_en  = 1'b0;
    rx_stall_en = 1'b0;
    repeat (100) send_tick(gen_tick(1'b1));
    tx_idle_en  = 1'b1;
    rx_stall_en = 1'b1;
    repeat (100) send_tick(gen_tick(1'b1));
    drain_ticks();
  endtask

  task automatic test_death_latch();
    death_cause_e cause;
    tick_t nominal;
    cause   = death_cause_e'($urandom_range(0, 2));
    nominal = mk_tick(100, 1, 1470, 2950, 50, 1000, 0, 0);
    write_config((cause == DEATH_BY_ZERO_HOLD) ? hold_t'(0) : hold_t'(50000), hold_t'(50000),
                 hold_t'(50000), hold_t'(50000),
                 (cause == DEATH_BY_EXPIRY) ? hold_t'(1) : hold_t'(50000), '1);
    send_tick(nominal);
    case (cause)
      DEATH_BY_EXPIRY: begin
        send_tick(mk_tick(7, 1, 1470, 2950, 4095, 65535, 0, 0));
        send_tick(mk_tick(7, 1, 1470, 2950, 4095, 65535, 0, 0));
      end
      DEATH_BY_LANDING: begin
        send_tick(mk_tick(7, 1, 1470, 2950, 4095, 1000, 0, -32768));
        send_tick(mk_tick(7, 1, 1470, 2950, 4095, 1000, 1, 0));
      end
      default: begin
        send_tick(mk_tick(7, 1, 0, 8191, 50, 1000, 0, 0));
      end
    endcase
    send_tick(nominal);
    send_tick(mk_tick(100, 0, 1470, 2950, 50, 1000, 0, 0));
    send_tick(mk_tick(100, 1, 1470, 2950, 50, 1000, 1, 0));
    repeat (20) send_tick(gen_tick(1'b0));
    drain_ticks();
  endtask

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      m_axis_tready <= 1'b0;
    end else if (rx_stall_en && $urandom_range(0, 3) == 0) begin
      rx_hold = idle_len() - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : status_check
    status_t want;
    if (rst_n && m_axis_tvalid && m_axis_tready) begin
      if (pending_status_q.size() == 0) begin
        report_mismatch("status beat with none pending", int'(m_axis_tdata), 0);
      end else begin
        want = pending_status_q.pop_front();
        if (m_axis_tdata[1:0] != want.crew_state)
          report_mismatch("crew_state", int'(m_axis_tdata[1:0]), int'(want.crew_state));
        if (m_axis_tdata[2] != want.became_dead)
          report_mismatch("became_dead", int'(m_axis_tdata[2]), int'(want.became_dead));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    health_q    = ST_OK;
    speed_lim_q = speed_t'(RESET_SPEED_LIM);
    air_speed_q = '0;
    episode_q   = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      hold_q[ch]  = hold_t'(RESET_HOLD[ch]);
      timer_q[ch] = clip_hold(hold_q[ch]);
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_boundaries();
    test_short_holds();
    test_extreme_holds();
    test_wide_holds();
    test_death_latch();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/hpm_pkg.sv
src/hpm_cfg_regs.sv
src/hpm_timer_bank.sv
src/hazard_persistence_monitor_core.sv
src/hpm_checker.sv
tb/tb_hazard_persistence_monitor_core.sv
